// ===== hdl/rtke_pkg.sv =====
// ---------------------------------------------------------------------------
// rtke_pkg: shared types and constants of the region top-k orientation unit
// Field widths, register codes, quantizer constants and the entry record
// passed between the pixel front end, the top-k bank and the drain buffer.
// ---------------------------------------------------------------------------
`default_nettype none

package rtke_pkg;

    localparam int MAG_W   = 15;
    localparam int ANG_W   = 15;
    localparam int COORD_W = 12;
    localparam int ORI_W   = 6;
    localparam int THR_W   = 15;
    localparam int KEEP_W  = 4;
    localparam int BINS_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // One full turn in 1/64 degree
    localparam int FULL_TURN = 23040;

    // ceil(x / 23040) = ceil(ceil(x / 512) / 45); the divide by 45 is a
    // reciprocal multiply: floor(z / 45) = (z * 11651) >> 19 for z < 74898
    localparam int CEIL_SHIFT  = 9;
    localparam int CEIL_ADD    = 511;
    localparam int DIV45_ADD   = 44;
    localparam int RECIP       = 11651;
    localparam int RECIP_W     = 14;
    localparam int RECIP_SHIFT = 19;

    localparam logic [THR_W-1:0]  THR_RESET  = 15'd208;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 4'd7;
    localparam logic [BINS_W-1:0] BINS_RESET = 7'd36;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_KEEP      = 2'd1,
        REG_BINS      = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [MAG_W-1:0]   mag;
        logic [ORI_W-1:0]   ori;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } entry_t;

    typedef struct packed {
        logic               pass;
        logic [MAG_W-1:0]   mag;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } pix_t;

    typedef struct packed {
        logic load;
        logic empty;
    } handoff_t;

endpackage

`default_nettype wire

// ===== hdl/rtke_front.sv =====
// ---------------------------------------------------------------------------
// rtke_front: pixel input register and angle product stage
// Register the pixel beat, test the threshold, wrap the angle and form
// angle * bins, then hold the result in a second register for the bank.
// ---------------------------------------------------------------------------
`default_nettype none

module rtke_front #(
    parameter int MAX_BINS = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [rtke_pkg::MAG_W-1:0]            magnitude,
    input  wire logic [rtke_pkg::ANG_W-1:0]            angle,
    input  wire logic [rtke_pkg::COORD_W-1:0]          pixel_col,
    input  wire logic [rtke_pkg::COORD_W-1:0]          pixel_row,
    input  wire logic                                  last_in_region,
    input  wire logic [rtke_pkg::THR_W-1:0]            threshold,
    input  wire logic [$clog2(MAX_BINS+1)-1:0]         eff_bins,
    output logic                                       b_valid,
    input  wire logic                                  b_fire,
    output rtke_pkg::pix_t                             b_pix,
    output logic [rtke_pkg::ANG_W+$clog2(MAX_BINS+1)-1:0] b_prod
);
    import rtke_pkg::*;

    localparam int BINE_W = $clog2(MAX_BINS + 1);
    localparam int PROD_W = ANG_W + BINE_W;

    logic                a_valid_reg;
    logic                a_valid_next;
    logic [MAG_W-1:0]    a_mag_reg;
    logic [ANG_W-1:0]    a_ang_reg;
    logic [COORD_W-1:0]  a_col_reg;
    logic [COORD_W-1:0]  a_row_reg;
    logic                a_last_reg;
    logic                b_valid_reg;
    logic                b_valid_next;
    pix_t                b_pix_reg;
    logic [PROD_W-1:0]   b_prod_reg;

    logic                a_move;
    logic                a_ready;
    logic [ANG_W-1:0]    ang_wrap;
    logic [PROD_W-1:0]   prod;

    assign a_move   = !b_valid_reg || b_fire;
    assign a_ready  = !a_valid_reg || a_move;
    assign in_stall = !a_ready;

    assign a_valid_next = a_ready ? in_valid : a_valid_reg;
    assign b_valid_next = a_move ? a_valid_reg : b_valid_reg;

    // wrap once modulo a full turn
    assign ang_wrap = (a_ang_reg >= ANG_W'(FULL_TURN)) ?
                      (a_ang_reg - ANG_W'(FULL_TURN)) : a_ang_reg;
    assign prod     = PROD_W'(ang_wrap) * PROD_W'(eff_bins);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            a_mag_reg  <= magnitude;
            a_ang_reg  <= angle;
            a_col_reg  <= pixel_col;
            a_row_reg  <= pixel_row;
            a_last_reg <= last_in_region;
        end
        if (a_valid_reg && a_move)
        begin
            b_pix_reg.pass <= (a_mag_reg >= threshold);
            b_pix_reg.mag  <= a_mag_reg;
            b_pix_reg.col  <= a_col_reg;
            b_pix_reg.row  <= a_row_reg;
            b_pix_reg.last <= a_last_reg;
            b_prod_reg     <= prod;
        end
    end

    assign b_valid = b_valid_reg;
    assign b_pix   = b_pix_reg;
    assign b_prod  = b_prod_reg;

endmodule

`default_nettype wire

// ===== hdl/rtke_bank.sv =====
// ---------------------------------------------------------------------------
// rtke_bank: orientation bin finish and sorted top-k store
// Finish the bin quantization, insert the pixel into the strongest-first
// slot list in one step, and hand the list to the drain at region end.
// ---------------------------------------------------------------------------
`default_nettype none

module rtke_bank #(
    parameter int MAX_KEEP = 8,
    parameter int MAX_BINS = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  b_valid,
    output logic                                       b_fire,
    input  wire rtke_pkg::pix_t                        b_pix,
    input  wire logic [rtke_pkg::ANG_W+$clog2(MAX_BINS+1)-1:0] b_prod,
    input  wire logic [$clog2(MAX_KEEP+1)-1:0]         eff_keep,
    input  wire logic [$clog2(MAX_BINS+1)-1:0]         eff_bins,
    input  wire logic                                  snap_free,
    output rtke_pkg::handoff_t                         handoff,
    output logic [$clog2(MAX_KEEP+1)-1:0]              load_count,
    output rtke_pkg::entry_t                           load_entries [MAX_KEEP]
);
    import rtke_pkg::*;

    localparam int CNT_W  = $clog2(MAX_KEEP + 1);
    localparam int BINE_W = $clog2(MAX_BINS + 1);
    localparam int PROD_W = ANG_W + BINE_W;
    localparam int Y_W    = PROD_W - CEIL_SHIFT + 1;
    localparam int Z_W    = Y_W + 1;
    localparam int ZR_W   = Z_W + RECIP_W;
    localparam int Q_W    = ZR_W - RECIP_SHIFT;

    entry_t              kept_reg  [MAX_KEEP];
    entry_t              kept_next [MAX_KEEP];
    logic [CNT_W-1:0]    total_reg;
    logic [CNT_W-1:0]    total_next;

    logic [PROD_W:0]     x_up;
    logic [Y_W-1:0]      y;
    logic [Z_W-1:0]      z;
    logic [ZR_W-1:0]     zr;
    logic [Q_W-1:0]      q;
    entry_t              new_entry;

    logic [CNT_W-1:0]    n;
    logic [MAX_KEEP-1:0] ge;
    logic [MAX_KEEP-1:0] within_k;
    logic                insert;
    logic [CNT_W-1:0]    total_after;
    logic [CNT_W-1:0]    emit_n;

    // ceil over 512, then ceil over 45 by reciprocal multiply
    assign x_up = {1'b0, b_prod} + (PROD_W+1)'(CEIL_ADD);
    assign y    = x_up[PROD_W:CEIL_SHIFT];
    assign z    = {1'b0, y} + Z_W'(DIV45_ADD);
    assign zr   = ZR_W'(z) * ZR_W'(RECIP);
    assign q    = zr[ZR_W-1:RECIP_SHIFT];

    always_comb
    begin
        new_entry.mag = b_pix.mag;
        new_entry.ori = (q >= Q_W'(eff_bins)) ? '0 : ORI_W'(q);
        new_entry.col = b_pix.col;
        new_entry.row = b_pix.row;
    end

    assign n = (total_reg > eff_keep) ? eff_keep : total_reg;

    // the list is sorted, so ge is a run of ones from slot 0
    always_comb
    begin
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            ge[i]       = (CNT_W'(i) < n) && (kept_reg[i].mag >= b_pix.mag);
            within_k[i] = (CNT_W'(i) < eff_keep);
        end
    end

    assign insert = b_pix.pass && (|(~ge & within_k));

    always_comb
    begin
        kept_next[0] = (!insert || ge[0]) ? kept_reg[0] : new_entry;
        for (int i = 1; i < MAX_KEEP; i++)
        begin
            if (!insert || ge[i])
                kept_next[i] = kept_reg[i];
            else if (ge[i-1])
                kept_next[i] = new_entry;
            else
                kept_next[i] = kept_reg[i-1];
        end
    end

    always_comb
    begin
        if (insert)
            total_after = (n == eff_keep) ? eff_keep : (n + CNT_W'(1));
        else if (b_pix.pass)
            total_after = n;
        else
            total_after = total_reg;
        emit_n = (total_after > eff_keep) ? eff_keep : total_after;
    end

    assign b_fire     = b_valid && (!b_pix.last || snap_free);
    assign total_next = b_pix.last ? '0 : total_after;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_reg <= '0;
        else if (b_fire)
            total_reg <= total_next;
    end

    always_ff @(posedge clk)
    begin
        if (b_fire)
        begin
            for (int i = 0; i < MAX_KEEP; i++)
                kept_reg[i] <= kept_next[i];
        end
    end

    assign handoff.load  = b_fire && b_pix.last;
    assign handoff.empty = (emit_n == '0);
    assign load_count    = emit_n;

    always_comb
    begin
        for (int i = 0; i < MAX_KEEP; i++)
            load_entries[i] = kept_next[i];
    end

endmodule

`default_nettype wire

// ===== hdl/rtke_drain.sv =====
// ---------------------------------------------------------------------------
// rtke_drain: region result buffer
// Hold one region's kept entries and shift them out strongest first, one
// beat per accepted output, flagging an empty region with a single beat.
// ---------------------------------------------------------------------------
`default_nettype none

module rtke_drain #(
    parameter int MAX_KEEP = 8
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire rtke_pkg::handoff_t                    handoff,
    input  wire logic [$clog2(MAX_KEEP+1)-1:0]         load_count,
    input  wire rtke_pkg::entry_t                      load_entries [MAX_KEEP],
    output logic                                       snap_free,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [rtke_pkg::MAG_W-1:0]                 entry_magnitude,
    output logic [rtke_pkg::ORI_W-1:0]                 entry_orientation,
    output logic [rtke_pkg::COORD_W-1:0]               entry_col,
    output logic [rtke_pkg::COORD_W-1:0]               entry_row,
    output logic                                       entry_valid,
    output logic                                       last_entry
);
    import rtke_pkg::*;

    localparam int CNT_W = $clog2(MAX_KEEP + 1);

    entry_t            snap_reg [MAX_KEEP];
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              empty_reg;
    logic              out_fire;

    assign out_valid = (cnt_reg != '0);
    assign out_fire  = out_valid && !out_stall;
    assign snap_free = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && !out_stall);

    always_comb
    begin
        if (handoff.load)
            cnt_next = handoff.empty ? CNT_W'(1) : load_count;
        else if (out_fire)
            cnt_next = cnt_reg - CNT_W'(1);
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            empty_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (handoff.load)
                empty_reg <= handoff.empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (handoff.load)
        begin
            // an empty region sends a single all-zero beat
            snap_reg[0] <= handoff.empty ? '0 : load_entries[0];
            for (int i = 1; i < MAX_KEEP; i++)
                snap_reg[i] <= load_entries[i];
        end
        else if (out_fire)
        begin
            for (int i = 0; i < MAX_KEEP - 1; i++)
                snap_reg[i] <= snap_reg[i+1];
        end
    end

    assign entry_magnitude   = snap_reg[0].mag;
    assign entry_orientation = snap_reg[0].ori;
    assign entry_col         = snap_reg[0].col;
    assign entry_row         = snap_reg[0].row;
    assign entry_valid       = !empty_reg;
    assign last_entry        = (cnt_reg == CNT_W'(1));

endmodule

`default_nettype wire

// ===== hdl/region_top_k_orientation_extract_unit.sv =====
// ---------------------------------------------------------------------------
// region_top_k_orientation_extract_unit: per-region strongest-pixel picker
// Keeps the strongest gradient pixels of each region with their quantized
// orientation and emits them strongest first at the region's end.
// ---------------------------------------------------------------------------
// Usage: the unit takes one pixel beat per cycle. A pixel passes through an
// input register and a product register (angle * bins) before it reaches
// the top-k bank, where the bin is finished and the pixel is inserted in
// one step. A region's first result beat is offered once its last pixel
// has passed both registers and the bank contents have moved at region end
// into a result buffer; the bank starts the next region at once and the
// buffer then shifts out one entry per accepted output beat (one to
// keep_count beats, a lone not-valid beat for an empty region). Input is held
// off only while a region's last pixel waits for the previous region's beats
// to be taken, so output stalls reach the input only at region ends. No
// clearing pass follows reset: slots past the fill count are never read.
// Registers: 0 threshold, 1 keep count, 2 bins; write them only while no
// pixel or result beat is in flight.
`default_nettype none

module region_top_k_orientation_extract_unit #(
    parameter int MAX_KEEP = 8,
    parameter int MAX_BINS = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // pixel channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [rtke_pkg::MAG_W-1:0]        magnitude,
    input  wire logic [rtke_pkg::ANG_W-1:0]        angle,
    input  wire logic [rtke_pkg::COORD_W-1:0]      pixel_col,
    input  wire logic [rtke_pkg::COORD_W-1:0]      pixel_row,
    input  wire logic                              last_in_region,
    // result channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [rtke_pkg::MAG_W-1:0]             entry_magnitude,
    output logic [rtke_pkg::ORI_W-1:0]             entry_orientation,
    output logic [rtke_pkg::COORD_W-1:0]           entry_col,
    output logic [rtke_pkg::COORD_W-1:0]           entry_row,
    output logic                                   entry_valid,
    output logic                                   last_entry,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [rtke_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rtke_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rtke_pkg::*;

    localparam int CNT_W   = $clog2(MAX_KEEP + 1);
    localparam int BINE_W  = $clog2(MAX_BINS + 1);
    localparam int PROD_W  = ANG_W + BINE_W;
    localparam int KCMP_W  = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;
    localparam int BCMP_W  = (BINE_W > BINS_W) ? BINE_W : BINS_W;
    localparam logic [KCMP_W-1:0] KEEP_LIMIT = KCMP_W'(MAX_KEEP);
    localparam logic [BCMP_W-1:0] BINS_LIMIT = BCMP_W'(MAX_BINS);

    logic [THR_W-1:0]   thr_reg;
    logic [KEEP_W-1:0]  keep_reg;
    logic [BINS_W-1:0]  bins_reg;

    logic [KCMP_W-1:0]  keep_wide;
    logic [BCMP_W-1:0]  bins_wide;
    logic [CNT_W-1:0]   eff_keep;
    logic [BINE_W-1:0]  eff_bins;

    logic               b_valid;
    logic               b_fire;
    pix_t               b_pix;
    logic [PROD_W-1:0]  b_prod;
    logic               snap_free;
    handoff_t           handoff;
    logic [CNT_W-1:0]   load_count;
    entry_t             load_entries [MAX_KEEP];

    // Register writes are always taken; an index past the list is dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            keep_reg <= KEEP_RESET;
            bins_reg <= BINS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: thr_reg  <= cfg_data[THR_W-1:0];
                REG_KEEP:      keep_reg <= cfg_data[KEEP_W-1:0];
                REG_BINS:      bins_reg <= cfg_data[BINS_W-1:0];
                default:       ;
            endcase
        end
    end

    // Zero counts act as one, large counts saturate at the build limits
    assign keep_wide = KCMP_W'(keep_reg);
    assign bins_wide = BCMP_W'(bins_reg);

    always_comb
    begin
        if (keep_wide == '0)
            eff_keep = CNT_W'(1);
        else if (keep_wide > KEEP_LIMIT)
            eff_keep = CNT_W'(MAX_KEEP);
        else
            eff_keep = CNT_W'(keep_wide);

        if (bins_wide == '0)
            eff_bins = BINE_W'(1);
        else if (bins_wide > BINS_LIMIT)
            eff_bins = BINE_W'(MAX_BINS);
        else
            eff_bins = BINE_W'(bins_wide);
    end

    // Input register, threshold test and angle product
    rtke_front #(
        .MAX_BINS (MAX_BINS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .magnitude      (magnitude),
        .angle          (angle),
        .pixel_col      (pixel_col),
        .pixel_row      (pixel_row),
        .last_in_region (last_in_region),
        .threshold      (thr_reg),
        .eff_bins       (eff_bins),
        .b_valid        (b_valid),
        .b_fire         (b_fire),
        .b_pix          (b_pix),
        .b_prod         (b_prod)
    );

    // Bin finish and sorted insertion; hand off at region end
    rtke_bank #(
        .MAX_KEEP (MAX_KEEP),
        .MAX_BINS (MAX_BINS)
    ) u_bank (
        .clk          (clk),
        .rst_n        (rst_n),
        .b_valid      (b_valid),
        .b_fire       (b_fire),
        .b_pix        (b_pix),
        .b_prod       (b_prod),
        .eff_keep     (eff_keep),
        .eff_bins     (eff_bins),
        .snap_free    (snap_free),
        .handoff      (handoff),
        .load_count   (load_count),
        .load_entries (load_entries)
    );

    // Result buffer: shift out one entry per output beat
    rtke_drain #(
        .MAX_KEEP (MAX_KEEP)
    ) u_drain (
        .clk               (clk),
        .rst_n             (rst_n),
        .handoff           (handoff),
        .load_count        (load_count),
        .load_entries      (load_entries),
        .snap_free         (snap_free),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .entry_magnitude   (entry_magnitude),
        .entry_orientation (entry_orientation),
        .entry_col         (entry_col),
        .entry_row         (entry_row),
        .entry_valid       (entry_valid),
        .last_entry        (last_entry)
    );

`ifndef SYNTH
    // An empty-region marker is always the region's only and final beat
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !entry_valid) |-> last_entry)
        else $error("not-valid entry without last_entry");

    // Within a region the beats come strongest first and without a gap
    a_strongest_first: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_entry) |=>
        (out_valid && entry_valid && (entry_magnitude <= $past(entry_magnitude))))
        else $error("region entries out of order");

    // A region hand-off only lands in a buffer that is free or freeing
    a_handoff_free: assert property (@(posedge clk) disable iff (!rst_n)
        handoff.load |-> (!out_valid || (last_entry && !out_stall)))
        else $error("region hand-off over pending entries");
`endif

endmodule

`default_nettype wire
